@@ design/tsm_pkg.sv @@
// ----------------------------------------------------------------------------
// tsm_pkg: shared types and helpers of the text substring matcher
// Holds the payload structs of both channels, the register codes, the
// window sizes and the byte classification functions.
// ----------------------------------------------------------------------------
package tsm_pkg;

  // Needle and window geometry.
  localparam int MAX_NEEDLE = 8;
  localparam int WIN_DEPTH  = MAX_NEEDLE + 1;
  localparam int SEQ_LEN    = WIN_DEPTH + 1;
  localparam int NLEN_W     = $clog2(MAX_NEEDLE);
  localparam int FILL_W     = $clog2(WIN_DEPTH + 1);
  localparam int WIN_IDX_W  = $clog2(WIN_DEPTH);

  // Counter width of position, line and match counters.
  localparam int CNT_W = 32;

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);
  localparam int PUSH_MAX   = 3;

  // Configuration port.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_BYTES  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LENGTH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXACT_CMP     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_MODE     = 8'd3;

  // Result kinds.
  localparam logic KIND_MATCH = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  typedef logic [CNT_W-1:0] count_t;

  // Input beat payload.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_t;

  // Result beat payload.
  typedef struct packed {
    logic        kind;
    logic [31:0] line_index;
    logic [31:0] column_index;
    logic [31:0] byte_position;
    logic [31:0] match_total;
    logic        run_last;
  } out_t;

  // Current byte followed by the stored window, most recent first.
  typedef logic [SEQ_LEN-1:0][7:0] seq_bytes_t;

  // Compare settings handed to the match unit.
  typedef struct packed {
    logic [63:0]       needle_bytes;
    logic [NLEN_W-1:0] len_idx;
    logic              exact_cmp;
    logic              word_mode;
  } match_cfg_t;

  // Match flags for the two candidate positions.
  typedef struct packed {
    logic end_prior;
    logic end_last;
  } match_hit_t;

  // One processing step's worth of results for the queue.
  typedef struct packed {
    logic [1:0]                   count;
    logic [PUSH_MAX-1:0][$bits(out_t)-1:0] entries;
  } fifo_push_t;

  // Saturating increment of a counter.
  function automatic count_t sat_inc(input count_t v);
    return (v == '1) ? v : count_t'(v + 1'b1);
  endfunction

  // Fold ASCII upper case to lower case unless the compare is exact.
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic exact);
    logic [7:0] r;
    r = c;
    if (!exact && c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // ASCII letter or digit.
  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

@@ design/tsm_match.sv @@
// ----------------------------------------------------------------------------
// tsm_match: parallel needle compare over the byte window
// Tests the needle against the candidate that ends at the previous byte and
// the one that ends at the current byte, with the word boundary checks.
// ----------------------------------------------------------------------------
module tsm_match
  import tsm_pkg::*;
(
  input  seq_bytes_t       seq_i,
  input  logic [FILL_W-1:0] fill_i,
  input  match_cfg_t       cfg_i,
  output match_hit_t       hit_o
);

  logic [MAX_NEEDLE-1:0] ok_prior;
  logic [MAX_NEEDLE-1:0] ok_last;

  // Evaluate every needle length at once; the configured one is picked below.
  always_comb begin
    logic eq_p;
    logic eq_l;
    logic [7:0] nb;
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      eq_p = 1'b1;
      eq_l = 1'b1;
      for (int j = 0; j < MAX_NEEDLE; j++) begin
        nb = fold_byte(cfg_i.needle_bytes[8*j +: 8], cfg_i.exact_cmp);
        if (j <= i) begin
          if (fold_byte(seq_i[i + 1 - j], cfg_i.exact_cmp) != nb) begin
            eq_p = 1'b0;
          end
          if (fold_byte(seq_i[i - j], cfg_i.exact_cmp) != nb) begin
            eq_l = 1'b0;
          end
        end
      end
      // Candidate ending at the previous byte: the current byte follows it.
      ok_prior[i] = (fill_i >= FILL_W'(i + 1)) && eq_p &&
                    !(cfg_i.word_mode &&
                      ((fill_i > FILL_W'(i + 1) && is_alnum(seq_i[i + 2])) ||
                       is_alnum(seq_i[0])));
      // Candidate ending at the current byte: the text edge follows it.
      ok_last[i]  = (fill_i >= FILL_W'(i)) && eq_l &&
                    !(cfg_i.word_mode &&
                      (fill_i >= FILL_W'(i + 1)) && is_alnum(seq_i[i + 1]));
    end
  end

  assign hit_o.end_prior = ok_prior[cfg_i.len_idx];
  assign hit_o.end_last  = ok_last[cfg_i.len_idx];

endmodule

@@ design/tsm_result_fifo.sv @@
// ----------------------------------------------------------------------------
// tsm_result_fifo: small result queue
// Takes up to three results in one cycle and releases one per beat on the
// output channel.
// ----------------------------------------------------------------------------
module tsm_result_fifo
  import tsm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fifo_push_t            push_i,
  input  logic                  pop_i,
  output out_t                  head_o,
  output logic [FIFO_LVL_W-1:0] level_o
);

  logic [$bits(out_t)-1:0] mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wptr_q, wptr_d;
  logic [FIFO_PTR_W-1:0]   rptr_q, rptr_d;
  logic [FIFO_LVL_W-1:0]   level_q, level_d;

  // Pointer and level bookkeeping.
  always_comb begin
    wptr_d  = FIFO_PTR_W'(wptr_q + FIFO_PTR_W'(push_i.count));
    rptr_d  = pop_i ? FIFO_PTR_W'(rptr_q + 1'b1) : rptr_q;
    level_d = FIFO_LVL_W'(level_q + FIFO_LVL_W'(push_i.count) -
                          FIFO_LVL_W'(pop_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      level_q <= level_d;
    end
  end

  // Storage: consecutive slots from the write pointer.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < PUSH_MAX; i++) begin
      if (2'(i) < push_i.count) begin
        mem_q[FIFO_PTR_W'(wptr_q + FIFO_PTR_W'(i))] <= push_i.entries[i];
      end
    end
  end

  assign head_o  = out_t'(mem_q[rptr_q]);
  assign level_o = level_q;

endmodule

@@ design/text_substring_matcher.sv @@
// ----------------------------------------------------------------------------
// text_substring_matcher: streaming needle search over a byte text
// Reports every occurrence of a 1 to 8 byte needle with its line, column
// and absolute offset, and a completion beat with the total on the last byte.
// ----------------------------------------------------------------------------
// Usage:
// The needle and options are written on the cfg channel (index 0 needle
// bytes, 1 length, 2 case sensitivity, 3 whole-word mode) while the block is
// idle; cfg_ready_o is always high.
// Text bytes arrive one per input beat, the final one flagged end_of_text.
// A beat is taken into an input register; the window compare then runs
// on it and its zero to three results enter a four-entry result queue
// once the queue has room for them, and the queue offers its oldest
// result on the output channel.
// Throughput is one byte per cycle unless stalled; the output channel
// carries one result per cycle, so the sustained byte rate follows the result
// rate when matches are dense. A byte leaves the input register only when
// the queue has room for all of its results; otherwise in_stall_o is raised.
// A stalled receiver fills the queue and then stalls the input side.
// The last byte clears all text state, so the next byte starts a new text.
// Reset clears the text state, empties the queue and restores the register
// defaults; the block accepts beats right after reset.
// ----------------------------------------------------------------------------
module text_substring_matcher
  import tsm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Text input channel.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  // Result output channel.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  // Configuration write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers.
  logic [63:0] needle_q;
  logic [3:0]  nlen_q;
  logic        case_q;
  logic        whole_q;

  // Input register.
  logic s1_valid_q, s1_valid_d;
  in_t  s1_data_q;

  // Text state.
  logic [7:0]        byte_win_q [WIN_DEPTH];
  count_t            line_win_q [WIN_DEPTH];
  count_t            col_win_q  [WIN_DEPTH];
  logic [FILL_W-1:0] fill_q, fill_d;
  count_t            pos_q, pos_d;
  count_t            line_q, line_d;
  count_t            begin_q, begin_d;
  logic              prior_nl_q, prior_nl_d;
  count_t            mc_q, mc_d;

  logic                  in_accept;
  logic                  s1_adv;
  logic                  pop;
  logic [FIFO_LVL_W-1:0] level;
  logic [FIFO_LVL_W:0]   room;
  fifo_push_t            push;
  match_cfg_t            mcfg;
  match_hit_t            hit;
  seq_bytes_t            seq;
  logic [NLEN_W-1:0]     len_idx;

  count_t line_cur, begin_cur, col_cur;
  count_t line_a, col_a, line_b, col_b;
  count_t mc1, mc2;
  logic   hit_a, hit_b, last;
  out_t   res_a, res_b, res_d;

  // Configuration writes.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_q <= '0;
      nlen_q   <= 4'd1;
      case_q   <= 1'b1;
      whole_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_NEEDLE_BYTES:  needle_q <= cfg_data_i;
        REG_NEEDLE_LENGTH: nlen_q   <= cfg_data_i[3:0];
        REG_EXACT_CMP:     case_q   <= cfg_data_i[0];
        REG_WORD_MODE:     whole_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Needle length clamped to 1..MAX_NEEDLE, kept as length minus one.
  always_comb begin
    if (nlen_q == 4'd0) begin
      len_idx = '0;
    end else if (nlen_q > 4'(MAX_NEEDLE)) begin
      len_idx = NLEN_W'(MAX_NEEDLE - 1);
    end else begin
      len_idx = NLEN_W'(nlen_q - 4'd1);
    end
  end

  assign mcfg.needle_bytes = needle_q;
  assign mcfg.len_idx      = len_idx;
  assign mcfg.exact_cmp    = case_q;
  assign mcfg.word_mode    = whole_q;

  // Line and column of the byte in the input register.
  always_comb begin
    line_cur  = prior_nl_q ? sat_inc(line_q) : line_q;
    begin_cur = prior_nl_q ? pos_q : begin_q;
    col_cur   = count_t'(pos_q - begin_cur);
  end

  // Current byte in front of the stored window.
  always_comb begin
    seq[0] = s1_data_q.text_byte;
    for (int k = 1; k < SEQ_LEN; k++) begin
      seq[k] = byte_win_q[k - 1];
    end
  end

  tsm_match u_match (
    .seq_i  (seq),
    .fill_i (fill_q),
    .cfg_i  (mcfg),
    .hit_o  (hit)
  );

  // Line and column of both candidate starts, picked by needle length.
  always_comb begin
    line_a = line_win_q[0];
    col_a  = col_win_q[0];
    line_b = line_cur;
    col_b  = col_cur;
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      if (len_idx == NLEN_W'(i)) begin
        line_a = line_win_q[i];
        col_a  = col_win_q[i];
      end
    end
    // A one-byte needle starts at the current byte itself.
    for (int i = 1; i < MAX_NEEDLE; i++) begin
      if (len_idx == NLEN_W'(i)) begin
        line_b = line_win_q[i - 1];
        col_b  = col_win_q[i - 1];
      end
    end
  end

  // Results of the byte in the input register, in delivery order.
  always_comb begin
    last  = s1_data_q.end_of_text;
    hit_a = s1_valid_q && hit.end_prior;
    hit_b = s1_valid_q && last && hit.end_last;
    mc1   = hit_a ? sat_inc(mc_q) : mc_q;
    mc2   = hit_b ? sat_inc(mc1) : mc1;

    res_a.kind          = KIND_MATCH;
    res_a.line_index    = 32'(line_a);
    res_a.column_index  = 32'(col_a);
    res_a.byte_position = 32'(pos_q - count_t'(len_idx) - count_t'(1));
    res_a.match_total   = 32'(mc1);
    res_a.run_last      = !last;

    res_b.kind          = KIND_MATCH;
    res_b.line_index    = 32'(line_b);
    res_b.column_index  = 32'(col_b);
    res_b.byte_position = 32'(pos_q - count_t'(len_idx));
    res_b.match_total   = 32'(mc2);
    res_b.run_last      = 1'b0;

    res_d.kind          = KIND_DONE;
    res_d.line_index    = '0;
    res_d.column_index  = '0;
    res_d.byte_position = '0;
    res_d.match_total   = 32'(mc2);
    res_d.run_last      = 1'b1;

    push.count = 2'(hit_a) + 2'(hit_b) + 2'(s1_valid_q && last);
    push.entries[2] = res_d;
    if (hit_a) begin
      push.entries[0] = res_a;
      push.entries[1] = hit_b ? res_b : res_d;
    end else begin
      push.entries[0] = hit_b ? res_b : res_d;
      push.entries[1] = res_d;
    end
  end

  // The byte moves on only when the queue can take all of its results.
  assign pop    = out_valid_o && !out_stall_i;
  assign room   = (FIFO_LVL_W + 1)'(FIFO_DEPTH) - (FIFO_LVL_W + 1)'(level) +
                  (FIFO_LVL_W + 1)'(pop);
  assign s1_adv = s1_valid_q && ((FIFO_LVL_W + 1)'(push.count) <= room);

  fifo_push_t push_gated;
  always_comb begin
    push_gated = push;
    if (!s1_adv) begin
      push_gated.count = 2'd0;
    end
  end

  tsm_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_gated),
    .pop_i   (pop),
    .head_o  (out_data_o),
    .level_o (level)
  );

  assign out_valid_o = (level != '0);

  // Input register handshake.
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_data_q <= in_data_i;
    end
  end

  // Text state update when a byte is processed.
  always_comb begin
    fill_d     = fill_q;
    pos_d      = pos_q;
    line_d     = line_q;
    begin_d    = begin_q;
    prior_nl_d = prior_nl_q;
    mc_d       = mc_q;
    if (s1_adv) begin
      if (last) begin
        fill_d     = '0;
        pos_d      = '0;
        line_d     = '0;
        begin_d    = '0;
        prior_nl_d = 1'b0;
        mc_d       = '0;
      end else begin
        fill_d     = (fill_q < FILL_W'(WIN_DEPTH)) ? FILL_W'(fill_q + 1'b1) : fill_q;
        pos_d      = sat_inc(pos_q);
        line_d     = line_cur;
        begin_d    = begin_cur;
        prior_nl_d = (s1_data_q.text_byte == NEWLINE_BYTE);
        mc_d       = mc2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      pos_q      <= '0;
      line_q     <= '0;
      begin_q    <= '0;
      prior_nl_q <= 1'b0;
      mc_q       <= '0;
    end else begin
      fill_q     <= fill_d;
      pos_q      <= pos_d;
      line_q     <= line_d;
      begin_q    <= begin_d;
      prior_nl_q <= prior_nl_d;
      mc_q       <= mc_d;
    end
  end

  // Window shift line; entries beyond the fill count are never used.
  always_ff @(posedge clk_i) begin
    if (s1_adv && !last) begin
      for (int k = WIN_DEPTH - 1; k > 0; k--) begin
        byte_win_q[k] <= byte_win_q[k - 1];
        line_win_q[k] <= line_win_q[k - 1];
        col_win_q[k]  <= col_win_q[k - 1];
      end
      byte_win_q[0] <= s1_data_q.text_byte;
      line_win_q[0] <= line_cur;
      col_win_q[0]  <= col_cur;
    end
  end

endmodule
